@@ design/ps2mc_pkg.sv @@
// ============================================================================
// ps2mc_pkg
// Shared constants for the PS/2 mouse packet cursor tracker.
// ============================================================================
package ps2mc_pkg;

    // Default text screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Field widths fixed by the packet format
    localparam int DATA_W   = 8;
    localparam int DELTA_W  = 9;
    localparam int BUTTON_W = 3;
    localparam int LEN_W    = 3;
    localparam int STEP_W   = 8;
    localparam int CFG_IDX_W = 2;

    // Largest step a register can hold, sets the position range
    localparam int STEP_MAX = 255;

    // Shortest packet: flags, X, Y
    localparam logic [LEN_W-1:0] MIN_LEN = 3'd3;
    localparam int PKT_BYTES = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PACKET_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y        = 2'd2;

    // Register reset values
    localparam logic [LEN_W-1:0]  PACKET_LENGTH_RST = 3'd3;
    localparam logic [STEP_W-1:0] STEP_X_RST        = 8'd8;
    localparam logic [STEP_W-1:0] STEP_Y_RST        = 8'd12;

    // Flag byte bit positions
    localparam int FLAG_X_SIGN = 4;
    localparam int FLAG_Y_SIGN = 5;

endpackage

@@ design/ps2mc_div.sv @@
// ============================================================================
// ps2mc_div
// Restoring divider, one quotient bit per cycle, 8-bit divisor.
// ============================================================================
module ps2mc_div
    import ps2mc_pkg::*;
#(
    parameter int W = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [W-1:0]      dividend,
    input  logic [STEP_W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient
);

    localparam int CNT_W = $clog2(W + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [W-1:0]      quo_reg, quo_next;
    logic [STEP_W-1:0] rem_reg, rem_next;
    logic [STEP_W:0]   rem_shift;
    logic [STEP_W:0]   rem_sub;
    logic [STEP_W-1:0] dvs_reg;

    assign rem_shift = {rem_reg, quo_reg[W-1]};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            cnt_next = CNT_W'(W);
            quo_next = dividend;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            // remainder stays below the divisor, so it fits in STEP_W bits
            if (rem_shift >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sub[STEP_W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[STEP_W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ design/ps2_mouse_packet_cursor_tracker.sv @@
// ============================================================================
// ps2_mouse_packet_cursor_tracker
// Collects PS/2 mouse bytes into packets, updates a clamped cursor position
// and reports buttons, deltas, position and old/new text-cell indices.
// ============================================================================
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, rx_byte               | byte in
//  out     | out_valid, out_ready, buttons ... new_cell | packet out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | reg write
//
//  A non-final byte is taken while the sequencer stays idle. The final
//  byte of a packet passes through the delta/clamp step, four runs of the
//  single shared divider (old X, old Y, new X, new Y) and the output load
//  before the result is offered; DIV_W is 15 at the default geometry.
//  in_ready drops while a packet is being worked on and while its result
//  waits for the output register to free up. Reset clears the byte counter
//  and cursor position at once and returns the registers to reset values.
//
module ps2_mouse_packet_cursor_tracker
    import ps2mc_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF,
    localparam int X_W    = $clog2((COLUMNS - 1) * STEP_MAX + 1),
    localparam int Y_W    = $clog2((ROWS - 1) * STEP_MAX + 1),
    localparam int CELL_W = $clog2(COLUMNS * ROWS)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // byte input
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [DATA_W-1:0]         rx_byte,
    // packet result
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [BUTTON_W-1:0]       buttons,
    output logic signed [DELTA_W-1:0] delta_x,
    output logic signed [DELTA_W-1:0] delta_y,
    output logic [X_W-1:0]            cursor_x,
    output logic [Y_W-1:0]            cursor_y,
    output logic                      moved,
    output logic [CELL_W-1:0]         old_cell,
    output logic [CELL_W-1:0]         new_cell,
    // register writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [DATA_W-1:0]         cfg_data
);

    localparam int DIV_W = (X_W > Y_W) ? X_W : Y_W;
    localparam int SX_W  = X_W + 2;   // signed sum width, X axis
    localparam int SY_W  = Y_W + 2;   // signed sum width, Y axis

    // sequencer codes
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CALC     = 3'd1;
    localparam logic [2:0] S_DIV_GO   = 3'd2;
    localparam logic [2:0] S_DIV_WAIT = 3'd3;
    localparam logic [2:0] S_OUT      = 3'd4;

    // divide operations, bit 0 picks the axis, bit 1 picks new position
    localparam logic [1:0] OP_OLD_X = 2'd0;
    localparam logic [1:0] OP_OLD_Y = 2'd1;
    localparam logic [1:0] OP_NEW_X = 2'd2;
    localparam logic [1:0] OP_NEW_Y = 2'd3;

    // ---------------- configuration registers ----------------
    logic [LEN_W-1:0]  packet_length_reg;
    logic [STEP_W-1:0] step_x_reg;
    logic [STEP_W-1:0] step_y_reg;
    logic [LEN_W-1:0]  len_eff;
    logic [STEP_W-1:0] sx_eff;
    logic [STEP_W-1:0] sy_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_length_reg <= PACKET_LENGTH_RST;
            step_x_reg        <= STEP_X_RST;
            step_y_reg        <= STEP_Y_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PACKET_LENGTH: packet_length_reg <= cfg_data[LEN_W-1:0];
                REG_STEP_X:        step_x_reg        <= cfg_data;
                REG_STEP_Y:        step_y_reg        <= cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // lengths below three act as three, zero steps act as one
    assign len_eff = (packet_length_reg < MIN_LEN) ? MIN_LEN : packet_length_reg;
    assign sx_eff  = (step_x_reg == '0) ? STEP_W'(1) : step_x_reg;
    assign sy_eff  = (step_y_reg == '0) ? STEP_W'(1) : step_y_reg;

    // ---------------- byte collection ----------------
    logic [2:0]        state_reg, state_next;
    logic [LEN_W-1:0]  byte_index_reg, byte_index_next;
    logic [LEN_W-1:0]  idx_inc;
    logic              in_fire;
    logic              last_byte;
    logic [DATA_W-1:0] pkt_reg [PKT_BYTES];

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign idx_inc   = byte_index_reg + 1'b1;   // wraps like the 3-bit counter
    assign last_byte = (idx_inc >= len_eff);

    always_comb
    begin
        byte_index_next = byte_index_reg;
        if (in_fire)
        begin
            byte_index_next = last_byte ? '0 : idx_inc;
        end
    end

    // wheel bytes past the third are counted, not kept
    always_ff @(posedge clk)
    begin
        if (in_fire && (byte_index_reg < LEN_W'(PKT_BYTES)))
        begin
            pkt_reg[byte_index_reg[1:0]] <= rx_byte;
        end
    end

    // ---------------- delta decode and clamp (S_CALC) ----------------
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [SX_W-1:0]    sum_x;
    logic signed [SY_W-1:0]    sum_y;
    logic [X_W-1:0]            hi_x;
    logic [Y_W-1:0]            hi_y;
    logic [X_W-1:0]            nx;
    logic [Y_W-1:0]            ny;

    assign dx = {pkt_reg[0][FLAG_X_SIGN], pkt_reg[1]};
    assign dy = {pkt_reg[0][FLAG_Y_SIGN], pkt_reg[2]};

    assign hi_x = X_W'((COLUMNS - 1) * int'(sx_eff));
    assign hi_y = Y_W'((ROWS - 1) * int'(sy_eff));

    logic [X_W-1:0] pos_x_reg, pos_x_next;
    logic [Y_W-1:0] pos_y_reg, pos_y_next;

    // X adds, Y subtracts (screen rows grow downward)
    assign sum_x = $signed({2'b00, pos_x_reg}) + SX_W'(dx);
    assign sum_y = $signed({2'b00, pos_y_reg}) - SY_W'(dy);

    always_comb
    begin
        priority if (sum_x < 0)
        begin
            nx = '0;
        end
        else if (sum_x > $signed({2'b00, hi_x}))
        begin
            nx = hi_x;
        end
        else
        begin
            nx = sum_x[X_W-1:0];
        end
    end

    always_comb
    begin
        priority if (sum_y < 0)
        begin
            ny = '0;
        end
        else if (sum_y > $signed({2'b00, hi_y}))
        begin
            ny = hi_y;
        end
        else
        begin
            ny = sum_y[Y_W-1:0];
        end
    end

    // ---------------- shared divider ----------------
    logic [1:0]        op_reg, op_next;
    logic              div_start;
    logic              div_done;
    logic [DIV_W-1:0]  div_dividend;
    logic [STEP_W-1:0] div_divisor;
    logic [DIV_W-1:0]  div_quo;
    logic [X_W-1:0]    old_x_reg;
    logic [Y_W-1:0]    old_y_reg;
    logic [X_W-1:0]    sel_x;
    logic [Y_W-1:0]    sel_y;

    assign sel_x        = op_reg[1] ? pos_x_reg : old_x_reg;
    assign sel_y        = op_reg[1] ? pos_y_reg : old_y_reg;
    assign div_dividend = op_reg[0] ? DIV_W'(sel_y) : DIV_W'(sel_x);
    assign div_divisor  = op_reg[0] ? sy_eff : sx_eff;
    assign div_start    = (state_reg == S_DIV_GO);

    ps2mc_div #(
        .W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // row quotient arrives second: cell = row * COLUMNS + column
    logic [DIV_W-1:0]  qx_reg;
    logic [CELL_W-1:0] cell_calc;

    assign cell_calc = CELL_W'(int'(div_quo) * COLUMNS + int'(qx_reg));

    // ---------------- sequencer ----------------
    logic out_load;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        out_load   = 1'b0;
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && last_byte)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                pos_x_next = nx;
                pos_y_next = ny;
                op_next    = OP_OLD_X;
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (op_reg == OP_NEW_Y)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        op_next    = op_reg + 1'b1;
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    logic out_valid_reg, out_valid_next;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_OLD_X;
            byte_index_reg <= '0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            byte_index_reg <= byte_index_next;
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // ---------------- working and output payload ----------------
    logic [BUTTON_W-1:0]       btn_reg;
    logic signed [DELTA_W-1:0] dx_reg;
    logic signed [DELTA_W-1:0] dy_reg;
    logic                      moved_reg;
    logic [CELL_W-1:0]         old_cell_reg;
    logic [CELL_W-1:0]         new_cell_reg;

    logic [BUTTON_W-1:0]       buttons_reg;
    logic signed [DELTA_W-1:0] delta_x_reg;
    logic signed [DELTA_W-1:0] delta_y_reg;
    logic [X_W-1:0]            cursor_x_reg;
    logic [Y_W-1:0]            cursor_y_reg;
    logic                      moved_out_reg;
    logic [CELL_W-1:0]         old_cell_out_reg;
    logic [CELL_W-1:0]         new_cell_out_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CALC)
        begin
            btn_reg   <= pkt_reg[0][BUTTON_W-1:0];
            dx_reg    <= dx;
            dy_reg    <= dy;
            moved_reg <= (nx != pos_x_reg) || (ny != pos_y_reg);
            old_x_reg <= pos_x_reg;
            old_y_reg <= pos_y_reg;
        end
        if ((state_reg == S_DIV_WAIT) && div_done)
        begin
            unique case (op_reg)
                OP_OLD_X: qx_reg       <= div_quo;
                OP_OLD_Y: old_cell_reg <= cell_calc;
                OP_NEW_X: qx_reg       <= div_quo;
                OP_NEW_Y: new_cell_reg <= cell_calc;
                default: ;
            endcase
        end
        if (out_load)
        begin
            buttons_reg      <= btn_reg;
            delta_x_reg      <= dx_reg;
            delta_y_reg      <= dy_reg;
            cursor_x_reg     <= pos_x_reg;
            cursor_y_reg     <= pos_y_reg;
            moved_out_reg    <= moved_reg;
            old_cell_out_reg <= old_cell_reg;
            new_cell_out_reg <= new_cell_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign buttons   = buttons_reg;
    assign delta_x   = delta_x_reg;
    assign delta_y   = delta_y_reg;
    assign cursor_x  = cursor_x_reg;
    assign cursor_y  = cursor_y_reg;
    assign moved     = moved_out_reg;
    assign old_cell  = old_cell_out_reg;
    assign new_cell  = new_cell_out_reg;

endmodule
